// ===== hw/rtl/sfd_pkg.sv =====
// ----------------------------------------------------------------------------
// Sensor frame decoder package
// Shared constants, the result record type and the CRC-8 byte update.
// ----------------------------------------------------------------------------
package sfd_pkg;

   // number of captured payload bytes (bytes 1 to 6 of a frame)
   localparam int unsigned NUM_CAP = 6;

   // CRC-8 generator, 0x18D, with the ninth (top) bit included
   localparam logic [8:0] CRC_POLY = 9'h18D;

   // one decoded frame, field 0 is the node id, field 5 the relay state
   typedef struct packed {
      logic                      frame_ok;
      logic [7:0]                frame_length;
      logic [NUM_CAP-1:0][7:0]   fields;
   } result_type;

   // bit-serial CRC-8, MSB first, no augmentation, eight steps per byte
   function automatic logic [7:0] crc8_byte(input logic [7:0] rem, input logic [7:0] din);
      logic [8:0] r;
      r = {1'b0, rem};
      for (int i = 7; i >= 0; i--) begin
         r = {r[7:0], din[i]};
         if (r[8]) begin
            r = r ^ CRC_POLY;
         end
      end
      return r[7:0];
   endfunction

endpackage

// ===== hw/rtl/sfd_in_reg.sv =====
// ----------------------------------------------------------------------------
// Sensor frame decoder input register
// Holds one accepted byte until the frame tracker consumes it.
// ----------------------------------------------------------------------------
module sfd_in_reg
   import sfd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_data_byte,
   input  logic       req_frame_start,
   input  logic       advance,
   output logic       item_valid,
   output logic [7:0] item_data,
   output logic       item_start
);

   logic       valid_ff, valid_in;
   logic [7:0] data_ff;
   logic       start_ff;

   // room when empty or when the held byte moves on this cycle
   assign req_ready = !valid_ff || advance;
   assign valid_in  = req_ready ? req_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload, loaded on each accepted transaction
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         data_ff  <= req_data_byte;
         start_ff <= req_frame_start;
      end
   end

   assign item_valid = valid_ff;
   assign item_data  = data_ff;
   assign item_start = start_ff;

endmodule

// ===== hw/rtl/sfd_frame_track.sv =====
// ----------------------------------------------------------------------------
// Sensor frame decoder frame tracker
// Byte position, length, running CRC and captured fields of the current frame.
// ----------------------------------------------------------------------------
module sfd_frame_track
   import sfd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       item_fire,
   input  logic [7:0] item_data,
   input  logic       item_start,
   output logic       result_fire,
   output result_type result
);

   logic [7:0]              crc_ff, crc_in;
   logic [7:0]              pos_ff, pos_in;
   logic [7:0]              len_ff, len_in;
   logic [NUM_CAP-1:0][7:0] cap_ff, cap_in;
   logic                    new_frame;
   logic [7:0]              crc_step;
   logic [7:0]              pos_inc;

   // a byte opens a frame when forced or when no frame is in progress
   assign new_frame = item_start || (pos_ff == 8'd0);
   assign crc_step  = crc8_byte(new_frame ? 8'h00 : crc_ff, item_data);
   assign pos_inc   = pos_ff + 8'd1;

   // next state and end-of-frame detection
   always_comb begin
      crc_in      = crc_ff;
      pos_in      = pos_ff;
      len_in      = len_ff;
      cap_in      = cap_ff;
      result_fire = 1'b0;
      if (item_fire) begin
         if (new_frame) begin
            len_in = item_data;
            cap_in = '0;
            if (item_data == 8'd0) begin
               // empty frame: CRC covers nothing
               crc_in      = 8'h00;
               pos_in      = 8'd0;
               result_fire = 1'b1;
            end else begin
               crc_in = crc_step;
               if (item_data == 8'd1) begin
                  pos_in      = 8'd0;
                  result_fire = 1'b1;
               end else begin
                  pos_in = 8'd1;
               end
            end
         end else begin
            crc_in = crc_step;
            for (int k = 0; k < NUM_CAP; k++) begin
               if (pos_ff == 8'(k + 1)) begin
                  cap_in[k] = item_data;
               end
            end
            if (pos_inc >= len_ff) begin
               pos_in      = 8'd0;
               result_fire = 1'b1;
            end else begin
               pos_in = pos_inc;
            end
         end
      end
   end

   // result record reflects the state after this byte
   assign result.frame_ok     = (crc_in == 8'h00);
   assign result.frame_length = len_in;
   assign result.fields       = cap_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff <= '0;
         pos_ff <= '0;
         len_ff <= '0;
         cap_ff <= '0;
      end else begin
         crc_ff <= crc_in;
         pos_ff <= pos_in;
         len_ff <= len_in;
         cap_ff <= cap_in;
      end
   end

endmodule

// ===== hw/rtl/sfd_out_reg.sv =====
// ----------------------------------------------------------------------------
// Sensor frame decoder result register
// Holds one finished frame record until the receiver takes it.
// ----------------------------------------------------------------------------
module sfd_out_reg
   import sfd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       load,
   input  result_type result_in,
   input  logic       rsp_ready,
   output logic       rsp_valid,
   output result_type result_out,
   output logic       advance
);

   logic       valid_ff, valid_in;
   result_type result_ff;

   // pipeline may move when the slot is free or being emptied
   assign advance = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid  = valid_ff;
   assign result_out = result_ff;

endmodule

// ===== hw/rtl/sensor_frame_decoder_crc8.sv =====
// ----------------------------------------------------------------------------
// Sensor frame decoder with CRC-8 check
// Top level: input register, frame tracker, result register.
// ----------------------------------------------------------------------------
// Usage:
//   req_ channel carries one received frame byte per transaction, the length
//   byte first; req_frame_start forces a byte to open a new frame and drops
//   any frame in progress without a result.
//   rsp_ channel carries one transaction per finished frame: CRC-8 (0x18D)
//   pass flag, length and the six captured bytes, zero where the frame is
//   too short to reach them.
//   The input register takes each byte at the accepting edge; the result
//   register takes a frame's record when its last byte is processed, which
//   waits while the result register is full and rsp_ready is low.
//   Throughput: one byte per cycle unless the receiver stalls; the eight CRC
//   steps of a byte sit in the logic between the two registers.
//   Reset clears both valid flags and the frame state, so the next byte is
//   taken as a length byte.
//   When the receiver stalls, the result register holds its record and the
//   input register keeps one byte; req_ready falls only when both are full
//   and rsp_ready is low.
// ----------------------------------------------------------------------------
module sensor_frame_decoder_crc8
   import sfd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_data_byte,
   input  logic       req_frame_start,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_frame_ok,
   output logic [7:0] rsp_frame_length,
   output logic [7:0] rsp_node_id,
   output logic [7:0] rsp_temp_whole,
   output logic [7:0] rsp_temp_hundredths,
   output logic [7:0] rsp_humi_whole,
   output logic [7:0] rsp_humi_hundredths,
   output logic [7:0] rsp_relay_state
);

   logic       advance;
   logic       item_valid;
   logic [7:0] item_data;
   logic       item_start;
   logic       item_fire;
   logic       result_fire;
   result_type result_next;
   result_type result_held;

   sfd_in_reg u_in_reg (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_data_byte   (req_data_byte),
      .req_frame_start (req_frame_start),
      .advance         (advance),
      .item_valid      (item_valid),
      .item_data       (item_data),
      .item_start      (item_start)
   );

   // held byte is processed when the result slot can take its outcome
   assign item_fire = item_valid && advance;

   sfd_frame_track u_frame_track (
      .clock       (clock),
      .reset       (reset),
      .item_fire   (item_fire),
      .item_data   (item_data),
      .item_start  (item_start),
      .result_fire (result_fire),
      .result      (result_next)
   );

   sfd_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .load       (result_fire),
      .result_in  (result_next),
      .rsp_ready  (rsp_ready),
      .rsp_valid  (rsp_valid),
      .result_out (result_held),
      .advance    (advance)
   );

   assign rsp_frame_ok        = result_held.frame_ok;
   assign rsp_frame_length    = result_held.frame_length;
   assign rsp_node_id         = result_held.fields[0];
   assign rsp_temp_whole      = result_held.fields[1];
   assign rsp_temp_hundredths = result_held.fields[2];
   assign rsp_humi_whole      = result_held.fields[3];
   assign rsp_humi_hundredths = result_held.fields[4];
   assign rsp_relay_state     = result_held.fields[5];

endmodule

// ===== hw/rtl/sfd_checker.sv =====
// ----------------------------------------------------------------------------
// Sensor frame decoder port checker
// Port-level properties of the decoder, bound to the top level.
// ----------------------------------------------------------------------------
module sfd_checker
   import sfd_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_frame_ok,
   input logic [7:0] rsp_frame_length,
   input logic [7:0] rsp_node_id,
   input logic [7:0] rsp_temp_whole,
   input logic [7:0] rsp_relay_state
);

   // no result survives reset
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid set after reset");

   // a stalled result keeps its record
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_frame_length)
         && $stable(rsp_frame_ok) && $stable(rsp_node_id))
      else $error("stalled result transaction changed");

   // empty frame always passes
   a_empty_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_length == 8'd0 |-> rsp_frame_ok)
      else $error("empty frame reported as failed");

   // bytes the frame does not reach read as zero
   a_short_node: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_length < 8'd2 |-> rsp_node_id == 8'd0
         && rsp_temp_whole == 8'd0)
      else $error("short frame carries captured bytes");

   a_short_relay: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_length < 8'd7 |-> rsp_relay_state == 8'd0)
      else $error("frame without byte 6 reports relay state");

endmodule

bind sensor_frame_decoder_crc8 sfd_checker u_sfd_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_frame_ok     (rsp_frame_ok),
   .rsp_frame_length (rsp_frame_length),
   .rsp_node_id      (rsp_node_id),
   .rsp_temp_whole   (rsp_temp_whole),
   .rsp_relay_state  (rsp_relay_state)
);
